FILE: hw/rtl/gf256_log_antilog_multiply_macros.svh
// Assertion macros used by the checker file.
`ifndef GF256_LOG_ANTILOG_MULTIPLY_MACROS_SVH
`define GF256_LOG_ANTILOG_MULTIPLY_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GFMUL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define GFMUL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gfmul_pkg.sv
package gfmul_pkg;

	localparam logic [8:0] FIELD_POLY  = 9'h11B;
	localparam logic [8:0] GROUP_ORDER = 9'd255;
	localparam logic [7:0] GEN_RESET   = 8'h03;

	typedef logic [7:0] elem_t;

	function automatic elem_t gf_mul(input elem_t x, input elem_t y);
		elem_t      acc;
		logic [8:0] sh;
		acc = '0;
		sh  = {1'b0, x};
		for (int k = 0; k < 8; k++) begin
			if (y[k]) acc ^= sh[7:0];
			sh = sh << 1;
			if (sh[8]) sh ^= FIELD_POLY;
		end
		return acc;
	endfunction

endpackage

FILE: hw/rtl/gf256_log_antilog_multiply.sv
// GF(2^8) multiplier (polynomial 0x11B) built on a log table and an antilog table.
// After reset the block clears the log table and then builds both tables for
// generator 3; each write of the generator register starts another build once
// the pipeline is empty. in_ready stays low during these passes. Otherwise one
// operand pair is taken every cycle while the output queue has room for every
// item in flight: the two log lookups (two copies of the log table), the add mod
// 255 and the antilog lookup run through the registered log and antilog reads, and
// a four-entry output queue with credit flow control absorbs a stalled consumer.
module gf256_log_antilog_multiply (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] left_operand,
	input  logic [7:0] right_operand,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] product,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_IDLE  = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	logic [1:0]          state_q;
	logic [7:0]          ctr_q;
	gfmul_pkg::elem_t    val_q;
	gfmul_pkg::elem_t    walk_gen_q;
	gfmul_pkg::elem_t    gen_q;
	logic                pend_q;

	logic                v_s1, zero_s1;
	logic                v_s2, zero_s2;

	gfmul_pkg::elem_t    fifo_q [QDEPTH];
	logic [QAW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]      cnt_q;

	logic                log_we, al_we;
	logic [7:0]          log_waddr, log_wdata, al_waddr, al_wdata;
	logic [7:0]          log_a, log_b, al_rdata, al_raddr;
	logic [8:0]          sum;
	logic                in_xfer, push, pop;
	logic [QCW+1:0]      occupancy;
	gfmul_pkg::elem_t    res;

	// table write control
	always_comb begin
		log_we    = 1'b0;
		al_we     = 1'b0;
		log_waddr = ctr_q;
		log_wdata = '0;
		al_waddr  = ctr_q;
		al_wdata  = val_q;
		case (state_q)
			ST_CLEAR: begin
				log_we = 1'b1;
			end
			ST_BUILD: begin
				log_we = 1'b1;
				al_we  = 1'b1;
				if (ctr_q != 8'hFF) begin
					log_waddr = val_q;
					log_wdata = ctr_q;
				end else begin
					log_waddr = '0;
					al_wdata  = 8'h01;
				end
			end
			default: begin
				log_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			ctr_q      <= '0;
			val_q      <= 8'h01;
			walk_gen_q <= gfmul_pkg::GEN_RESET;
			gen_q      <= gfmul_pkg::GEN_RESET;
			pend_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				gen_q  <= cfg_wdata;
				pend_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					ctr_q <= ctr_q + 8'd1;
					if (ctr_q == 8'hFF) begin
						state_q    <= ST_BUILD;
						val_q      <= 8'h01;
						walk_gen_q <= gfmul_pkg::GEN_RESET;
					end
				end
				ST_BUILD: begin
					ctr_q <= ctr_q + 8'd1;
					val_q <= gfmul_pkg::gf_mul(val_q, walk_gen_q);
					if (ctr_q == 8'hFF) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pend_q && !cfg_we && !v_s1 && !v_s2) begin
						state_q    <= ST_BUILD;
						ctr_q      <= '0;
						val_q      <= 8'h01;
						walk_gen_q <= gen_q;
						pend_q     <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	gfmul_ram #(.WIDTH(8), .DEPTH(256)) u_log_a (
		.clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
		.raddr(left_operand), .rdata(log_a)
	);

	gfmul_ram #(.WIDTH(8), .DEPTH(256)) u_log_b (
		.clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
		.raddr(right_operand), .rdata(log_b)
	);

	gfmul_ram #(.WIDTH(8), .DEPTH(256)) u_antilog (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(al_raddr), .rdata(al_rdata)
	);

	// admit only when the queue can hold every item in flight
	assign occupancy = {2'b00, cnt_q} + {{(QCW+1){1'b0}}, v_s1} + {{(QCW+1){1'b0}}, v_s2};
	assign in_ready  = (state_q == ST_IDLE) && !pend_q && (occupancy < (QCW+2)'(QDEPTH));
	assign in_xfer   = in_valid && in_ready;

	assign sum      = {1'b0, log_a} + {1'b0, log_b};
	assign al_raddr = (sum >= gfmul_pkg::GROUP_ORDER) ? 8'(sum - gfmul_pkg::GROUP_ORDER)
	                                                  : sum[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (left_operand == 8'h00) || (right_operand == 8'h00);
		zero_s2 <= zero_s1;
	end

	assign res  = zero_s2 ? 8'h00 : al_rdata;
	assign push = v_s2;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= res;
	end

	assign out_valid = (cnt_q != '0);
	assign product   = fifo_q[rd_ptr_q];

endmodule

FILE: hw/rtl/gfmul_ram.sv
module gfmul_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/gfmul_checker.sv
`include "gf256_log_antilog_multiply_macros.svh"

module gfmul_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] product,
	input logic       cfg_we
);

	logic [3:0] outstanding_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// track transfers in minus transfers out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 4'(in_xfer) - 4'(out_xfer);
		end
	end

	`GFMUL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(product), "stall not held")
	`GFMUL_ASSERT_NEXT(a_cfg_busy, cfg_we, !in_ready, "input taken during table rebuild")
	`GFMUL_ASSERT(a_no_spurious, !out_valid || (outstanding_q != 4'd0), "result without matching input")
	`GFMUL_ASSERT(a_bounded, outstanding_q <= 4'd4, "more items in flight than queue depth")

endmodule

bind gf256_log_antilog_multiply gfmul_checker u_gfmul_checker (.*);

FILE: bench/gf256_log_antilog_multiply_test.sv
`timescale 1ns / 1ps

module gf256_log_antilog_multiply_test;

	typedef gfmul_pkg::elem_t elem_t;

	typedef struct {
		elem_t left;
		elem_t right;
		bit    typed;
		elem_t want;
	} directed_row_t;

	typedef struct {
		int gen;
		int idle;
		int stall;
		int count;
		int hold;
	} phase_t;

	typedef struct {
		elem_t product;
		int    seq;
	} expected_product_t;

	localparam int GEN_RANDOM = -1;
	localparam int NUM_DIRECTED = 19;
	localparam int NUM_PHASES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] left_operand = '0;
	logic [7:0] right_operand = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] product;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	elem_t gen_value;
	elem_t log_of [256];
	elem_t power_of [256];

	expected_product_t expected_products [$];
	expected_product_t head;

	int idle_pct = 0;
	int stall_pct = 0;
	int receiver_hold = 0;
	int item_count = 0;
	int error_count = 0;
	int drain_wait;
	elem_t rand_gen;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{8'h00, 8'h00, 1'b1, 8'h00},
		'{8'h00, 8'hFF, 1'b1, 8'h00},
		'{8'hFF, 8'h00, 1'b1, 8'h00},
		'{8'h00, 8'h01, 1'b1, 8'h00},
		'{8'h01, 8'h01, 1'b1, 8'h01},
		'{8'h01, 8'hFF, 1'b1, 8'hFF},
		'{8'hFF, 8'h01, 1'b1, 8'hFF},
		'{8'h80, 8'h01, 1'b1, 8'h80},
		'{8'h02, 8'h02, 1'b1, 8'h04},
		'{8'h03, 8'h03, 1'b1, 8'h05},
		'{8'h02, 8'h80, 1'b1, 8'h1B},
		'{8'h02, 8'h87, 1'b1, 8'h15},
		'{8'h57, 8'h83, 1'b1, 8'hC1},
		'{8'h57, 8'h13, 1'b1, 8'hFE},
		'{8'h53, 8'hCA, 1'b1, 8'h01},
		'{8'hFF, 8'hFF, 1'b0, 8'h00},
		'{8'h80, 8'h80, 1'b0, 8'h00},
		'{8'h7F, 8'hFE, 1'b0, 8'h00},
		'{8'h55, 8'hAA, 1'b0, 8'h00}
	};

	phase_t phases [NUM_PHASES] = '{
		'{3,          0,  0,  60, 0},
		'{0,          69, 0,  55, 0},
		'{255,        0,  69, 55, 0},
		'{2,          36, 36, 55, 0},
		'{1,          0,  0,  55, 80},
		'{GEN_RANDOM, 69, 0,  55, 0},
		'{3,          0,  69, 55, 0},
		'{GEN_RANDOM, 36, 36, 55, 0}
	};

	gf256_log_antilog_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_operand (left_operand),
		.right_operand(right_operand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.product      (product),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic elem_t field_product(input elem_t x, input elem_t y);
		elem_t acc;
		elem_t term;
		elem_t rest;
		acc = '0;
		term = x;
		rest = y;
		while (rest != 0) begin
			if (rest[0])
				acc ^= term;
			rest = rest >> 1;
			term = {term[6:0], 1'b0} ^ (term[7] ? gfmul_pkg::FIELD_POLY[7:0] : 8'h00);
		end
		return acc;
	endfunction

	function automatic void rebuild_tables();
		elem_t walk;
		walk = 8'h01;
		for (int i = 0; i < 255; i++) begin
			power_of[i] = walk;
			log_of[walk] = elem_t'(i);
			walk = field_product(walk, gen_value);
		end
		log_of[0] = '0;
		power_of[255] = power_of[0];
	endfunction

	function automatic elem_t predict_product(input elem_t a, input elem_t b);
		int sum;
		if (a == 0 || b == 0)
			return '0;
		sum = (int'(log_of[a]) + int'(log_of[b])) % 255;
		return power_of[sum];
	endfunction

	function automatic elem_t pick_operand();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'h00;
		if (r < 14)
			return 8'h01;
		if (r < 20)
			return 8'hFF;
		return elem_t'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string what, input int seq, input elem_t got,
		input elem_t want);
		$display("MISMATCH %s (item %0d): got %02h, want %02h", what, seq, got, want);
		error_count++;
	endtask

	task automatic offer_pair(input elem_t a, input elem_t b, input bit typed,
		input elem_t want);
		expected_product_t e;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		left_operand <= a;
		right_operand <= b;
		do
			@(posedge clk);
		while (!in_ready);
		e.product = typed ? want : predict_product(a, b);
		e.seq = item_count;
		item_count++;
		expected_products.push_back(e);
	endtask

	task automatic drain_and_write(input elem_t g);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_value = g;
		rebuild_tables();
	endtask

	always begin
		@(negedge clk);
		if (receiver_hold > 0) begin
			out_ready <= 1'b0;
			receiver_hold--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_products.size() == 0) begin
				report_mismatch("product with nothing pending", -1, product, 8'h00);
			end else begin
				head = expected_products.pop_front();
				if (product !== head.product)
					report_mismatch("product", head.seq, product, head.product);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		gen_value = gfmul_pkg::GEN_RESET;
		for (int i = 0; i < 256; i++) begin
			log_of[i] = '0;
			power_of[i] = '0;
		end
		rebuild_tables();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_pair(directed_rows[i].left, directed_rows[i].right,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			rand_gen = elem_t'($urandom_range(255));
			drain_and_write(phases[p].gen == GEN_RANDOM ? rand_gen : elem_t'(phases[p].gen));
			idle_pct = phases[p].idle;
			stall_pct = phases[p].stall;
			receiver_hold = phases[p].hold;
			for (int n = 0; n < phases[p].count; n++)
				offer_pair(pick_operand(), pick_operand(), 1'b0, 8'h00);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		drain_wait = 0;
		while (expected_products.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (16) @(posedge clk);
		if (expected_products.size() != 0)
			report_mismatch("results never delivered", expected_products[0].seq, 8'h00,
				expected_products[0].product);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gfmul_pkg.sv
hw/rtl/gfmul_ram.sv
hw/rtl/gf256_log_antilog_multiply.sv
hw/rtl/gfmul_checker.sv
bench/gf256_log_antilog_multiply_test.sv
